// ===== design/kpi_pkg.sv =====
// Shared types and constants of the keyframe pose interpolator.
// Used by kpi_ctrl, kpi_dp and keyframe_pose_interpolator_top; no dependencies.
`timescale 1ns / 1ps

package kpi_pkg;

  // Table geometry
  localparam int MAX_POINTS = 16;
  localparam int PTR_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int NUM_AXES   = 3;
  localparam int NUM_VALS   = 2 * NUM_AXES;
  localparam int VAL_W      = $clog2(NUM_VALS);
  localparam int HELD_W     = 5;

  // Divider: 31 quotient bits below the saturation point
  localparam int DIV_STEPS  = 31;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // round(pi * 2^32 / 180)
  localparam logic [26:0] RAD_PER_DEG_Q32 = 27'd74961321;

  // Item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic CFG_THREE_AXIS = 1'b0;
  localparam logic CFG_EPSILON    = 1'b1;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_ORDER       = 3'd1,
    ST_FULL        = 3'd2,
    ST_NO_INTERVAL = 3'd3,
    ST_TOO_FEW     = 3'd4
  } status_e;

  typedef struct packed {
    logic               op;
    logic        [31:0] time_value;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
    logic signed [31:0] angle_x;
    logic signed [31:0] angle_y;
    logic signed [31:0] angle_z;
  } in_item_t;

  typedef struct packed {
    logic        [2:0]        status;
    logic signed [31:0]       pose_x;
    logic signed [31:0]       pose_y;
    logic signed [31:0]       pose_z;
    logic signed [31:0]       turn_first;
    logic signed [31:0]       turn_second;
    logic signed [31:0]       turn_third;
    logic        [HELD_W-1:0] points_held;
  } out_item_t;

  // One stored control point
  typedef struct packed {
    logic [NUM_AXES-1:0][31:0] angle;
    logic [NUM_AXES-1:0][31:0] shift;
    logic [31:0]               ptime;
  } point_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    capture;
    logic    rd_a;
    logic    a_sel_lo;
    logic    rd_b;
    logic    write_point;
    logic    set_status;
    status_e status;
    logic    mul_last;
    logic    srch_clr;
    logic    srch_inc;
    logic    latch_frac;
    logic    div_init;
    logic    div_step;
    logic    lerp_mul;
    logic    lerp_sum;
    logic    rad_mul;
    logic    rad_fin;
    logic    j_inc;
    logic    emit;
  } kpi_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_load;
    logic few;
    logic full;
    logic order;
    logic nohit;
    logic hit;
    logic idx_zero;
    logic idx_last;
    logic div_last;
    logic j_angle;
    logic j_last;
    logic out_free;
  } kpi_flags_t;

endpackage

// ===== design/kpi_ctrl.sv =====
// Sequencer of the keyframe pose interpolator: one item at a time.
// Depends on kpi_pkg; drives kpi_dp through kpi_cmd_t.
`timescale 1ns / 1ps

module kpi_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  kpi_pkg::kpi_flags_t flags_i,
  output kpi_pkg::kpi_cmd_t   cmd_o
);
  import kpi_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_LD_CHK = 4'd2;
  localparam logic [3:0] S_Q_MUL  = 4'd3;
  localparam logic [3:0] S_Q_TEST = 4'd4;
  localparam logic [3:0] S_SR_RD  = 4'd5;
  localparam logic [3:0] S_SR_CMP = 4'd6;
  localparam logic [3:0] S_ROWS   = 4'd7;
  localparam logic [3:0] S_FRAC   = 4'd8;
  localparam logic [3:0] S_DIV0   = 4'd9;
  localparam logic [3:0] S_DIV    = 4'd10;
  localparam logic [3:0] S_L_MUL  = 4'd11;
  localparam logic [3:0] S_L_SUM  = 4'd12;
  localparam logic [3:0] S_R_MUL  = 4'd13;
  localparam logic [3:0] S_R_FIN  = 4'd14;
  localparam logic [3:0] S_FIN    = 4'd15;

  logic [3:0] state_q, state_d;

  // Next state and command decode
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.status = ST_OK;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISP;
        end
      end
      S_DISP: begin
        if (flags_i.is_load) begin
          cmd_o.rd_a = 1'b1;
          state_d    = S_LD_CHK;
        end else if (flags_i.few) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_TOO_FEW;
          state_d          = S_FIN;
        end else begin
          cmd_o.rd_a = 1'b1;
          state_d    = S_Q_MUL;
        end
      end
      S_LD_CHK: begin
        priority if (flags_i.full) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_FULL;
        end else if (flags_i.order) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_ORDER;
        end else begin
          cmd_o.write_point = 1'b1;
        end
        state_d = S_FIN;
      end
      S_Q_MUL: begin
        cmd_o.mul_last = 1'b1;
        cmd_o.srch_clr = 1'b1;
        state_d        = S_Q_TEST;
      end
      S_Q_TEST: begin
        if (flags_i.nohit) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_NO_INTERVAL;
          state_d          = S_FIN;
        end else begin
          state_d = S_SR_RD;
        end
      end
      S_SR_RD: begin
        cmd_o.rd_b = 1'b1;
        state_d    = S_SR_CMP;
      end
      S_SR_CMP: begin
        priority if (flags_i.hit && flags_i.idx_zero) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_NO_INTERVAL;
          state_d          = S_FIN;
        end else if (flags_i.hit) begin
          state_d = S_ROWS;
        end else if (flags_i.idx_last) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_NO_INTERVAL;
          state_d          = S_FIN;
        end else begin
          cmd_o.srch_inc = 1'b1;
          state_d        = S_SR_RD;
        end
      end
      S_ROWS: begin
        cmd_o.rd_a     = 1'b1;
        cmd_o.a_sel_lo = 1'b1;
        cmd_o.rd_b     = 1'b1;
        state_d        = S_FRAC;
      end
      S_FRAC: begin
        cmd_o.latch_frac = 1'b1;
        state_d          = S_DIV0;
      end
      S_DIV0: begin
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (flags_i.div_last) begin
          state_d = S_L_MUL;
        end
      end
      S_L_MUL: begin
        cmd_o.lerp_mul = 1'b1;
        state_d        = S_L_SUM;
      end
      S_L_SUM: begin
        cmd_o.lerp_sum = 1'b1;
        if (flags_i.j_angle) begin
          state_d = S_R_MUL;
        end else begin
          cmd_o.j_inc = 1'b1;
          state_d     = S_L_MUL;
        end
      end
      S_R_MUL: begin
        cmd_o.rad_mul = 1'b1;
        state_d       = S_R_FIN;
      end
      S_R_FIN: begin
        cmd_o.rad_fin = 1'b1;
        if (flags_i.j_last) begin
          state_d = S_FIN;
        end else begin
          cmd_o.j_inc = 1'b1;
          state_d     = S_L_MUL;
        end
      end
      S_FIN: begin
        if (flags_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/kpi_dp.sv =====
// Datapath of the keyframe pose interpolator: point table, search, divider,
// interpolation multiplier, configuration and output registers. Depends on kpi_pkg.
`timescale 1ns / 1ps

module kpi_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_addr_i,
  input  logic [15:0]         cfg_data_i,
  input  kpi_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output kpi_pkg::out_item_t  out_data_o,
  input  kpi_pkg::kpi_cmd_t   cmd_i,
  output kpi_pkg::kpi_flags_t flags_o
);
  import kpi_pkg::*;

  // Configuration
  logic        three_axis_q;
  logic [15:0] eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      three_axis_q <= 1'b1;
      eps_q        <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_THREE_AXIS: three_axis_q <= cfg_data_i[0];
        CFG_EPSILON:    eps_q        <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  // Item, status and point count
  in_item_t          item_q;
  status_e           status_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  cnt_m1;

  assign cnt_m1 = count_q - CNT_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      status_q <= ST_OK;
    end else begin
      if (cmd_i.capture) begin
        status_q <= ST_OK;
      end else if (cmd_i.set_status) begin
        status_q <= cmd_i.status;
      end
      if (cmd_i.write_point) begin
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  // Point table: one write port, two registered read ports
  point_t            row_mem [MAX_POINTS];
  point_t            rd_a_q, rd_b_q, new_row;
  logic [PTR_W-1:0]  idx_q;
  logic [PTR_W-1:0]  addr_a;

  assign addr_a = cmd_i.a_sel_lo ? (idx_q - PTR_W'(1)) : cnt_m1[PTR_W-1:0];

  always_comb begin
    new_row.ptime = item_q.time_value;
    new_row.shift = {item_q.shift_z, item_q.shift_y, item_q.shift_x};
    new_row.angle = {item_q.angle_z, item_q.angle_y, item_q.angle_x};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_point) begin
      row_mem[count_q[PTR_W-1:0]] <= new_row;
    end
    if (cmd_i.rd_a) begin
      rd_a_q <= row_mem[addr_a];
    end
    if (cmd_i.rd_b) begin
      rd_b_q <= row_mem[idx_q];
    end
  end

  // Search: scaled query time against each stored time
  logic [32:0] fe;
  logic [47:0] lhs_d, tl_d;
  logic [47:0] lhs_q, tl_q;
  logic        nohit_q;

  assign fe    = {1'b0, item_q.time_value} + {17'b0, eps_q};
  assign lhs_d = fe[15:0] * rd_a_q.ptime;
  assign tl_d  = item_q.time_value[15:0] * rd_a_q.ptime;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_last) begin
      lhs_q   <= lhs_d;
      tl_q    <= tl_d;
      nohit_q <= |fe[32:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.srch_clr) begin
      idx_q <= '0;
    end else if (cmd_i.srch_inc) begin
      idx_q <= idx_q + PTR_W'(1);
    end
  end

  // Fraction numerator and interval width
  logic signed [48:0] num;
  logic        [48:0] mag_q;
  logic               neg_q;
  logic        [31:0] d_q;

  assign num = $signed({1'b0, tl_q}) - $signed({1'b0, rd_a_q.ptime, 16'h0});

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_frac) begin
      neg_q <= num[48];
      mag_q <= num[48] ? 49'(-num) : 49'(num);
      d_q   <= rd_b_q.ptime - rd_a_q.ptime;
    end
  end

  // Restoring divider, one quotient bit a cycle
  logic [48:0]          rem_q;
  logic [61:0]          dsh_q;
  logic [30:0]          quo_q;
  logic [DIV_CNT_W-1:0] bit_q;
  logic                 sat_q;
  logic                 ge;

  assign ge = {13'b0, rem_q} >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else if (cmd_i.div_init) begin
      bit_q <= DIV_CNT_W'(DIV_STEPS - 1);
    end else if (cmd_i.div_step) begin
      bit_q <= bit_q - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      sat_q <= {14'b0, mag_q[48:31]} >= d_q;
      rem_q <= mag_q;
      dsh_q <= {d_q, 30'b0};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q[48:0];
      end
      quo_q <= {quo_q[29:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  // Signed Q16.16 factor, magnitude saturated to 2^31
  logic        [32:0] fmag;
  logic signed [32:0] fac;

  assign fmag = sat_q ? 33'h0_8000_0000 : {2'b0, quo_q};
  assign fac  = neg_q ? $signed(-fmag) : $signed(fmag);

  // Interpolation over the six values on one shared multiplier; radians use a second
  logic [NUM_VALS-1:0][31:0] lo_all, hi_all;
  logic [VAL_W-1:0]          j_q;
  logic signed [32:0]        diff;
  logic signed [65:0]        prod_q, prod_adj;
  logic signed [50:0]        sum;
  logic signed [31:0]        val, val_q;
  logic signed [59:0]        rprod_q, rprod_adj;
  logic [NUM_VALS-1:0][31:0] res_q;

  assign lo_all = {rd_a_q.angle, rd_a_q.shift};
  assign hi_all = {rd_b_q.angle, rd_b_q.shift};
  assign diff   = $signed({hi_all[j_q][31], hi_all[j_q]})
                - $signed({lo_all[j_q][31], lo_all[j_q]});

  // Truncate toward zero on the shifts by adding the bias on negatives
  assign prod_adj  = prod_q + (prod_q[65] ? 66'sd65535 : 66'sd0);
  assign sum       = $signed({{19{lo_all[j_q][31]}}, lo_all[j_q]})
                   + $signed({prod_adj[65], prod_adj[65:16]});
  assign rprod_adj = rprod_q + (rprod_q[59] ? 60'sh0_FFFF_FFFF : 60'sd0);

  always_comb begin
    if (sum[50:31] != {20{sum[31]}}) begin
      val = sum[50] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      val = sum[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q <= '0;
    end else if (cmd_i.div_init) begin
      j_q <= '0;
    end else if (cmd_i.j_inc) begin
      j_q <= j_q + VAL_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lerp_mul) begin
      prod_q <= diff * fac;
    end
    if (cmd_i.rad_mul) begin
      rprod_q <= val_q * $signed({1'b0, RAD_PER_DEG_Q32});
    end
    if (cmd_i.capture) begin
      res_q <= '0;
    end else if (cmd_i.lerp_sum) begin
      if (j_q < VAL_W'(NUM_AXES)) begin
        res_q[j_q] <= val;
      end else begin
        val_q <= val;
      end
    end else if (cmd_i.rad_fin) begin
      res_q[j_q] <= {{4{rprod_adj[59]}}, rprod_adj[59:32]};
    end
  end

  // Output register
  logic      out_valid_q;
  out_item_t out_q, out_d;

  always_comb begin
    out_d.status      = status_q;
    out_d.pose_x      = res_q[0];
    out_d.pose_y      = res_q[1];
    out_d.pose_z      = res_q[2];
    if (three_axis_q) begin
      out_d.turn_first  = res_q[3];
      out_d.turn_second = res_q[4];
      out_d.turn_third  = res_q[5];
    end else begin
      out_d.turn_first  = res_q[5];
      out_d.turn_second = res_q[3];
      out_d.turn_third  = '0;
    end
    out_d.points_held = HELD_W'(count_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status towards the sequencer
  always_comb begin
    flags_o.is_load  = item_q.op == OP_LOAD;
    flags_o.few      = count_q < CNT_W'(2);
    flags_o.full     = count_q >= CNT_W'(MAX_POINTS);
    flags_o.order    = (count_q != '0) && (item_q.time_value < rd_a_q.ptime);
    flags_o.nohit    = nohit_q;
    flags_o.hit      = lhs_q < {rd_b_q.ptime, 16'h0};
    flags_o.idx_zero = idx_q == '0;
    flags_o.idx_last = idx_q == cnt_m1[PTR_W-1:0];
    flags_o.div_last = bit_q == '0;
    flags_o.j_angle  = j_q >= VAL_W'(NUM_AXES);
    flags_o.j_last   = j_q == VAL_W'(NUM_VALS - 1);
    flags_o.out_free = !out_valid_q || out_ready_i;
  end

  // Checks
  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_point |-> count_q < CNT_W'(MAX_POINTS))
    else $error("point written into a full table");

  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_point |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("point count did not advance on write");

  a_width_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_init |-> d_q != '0)
    else $error("interpolation interval of zero width");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote an untaken beat");

endmodule

// ===== design/keyframe_pose_interpolator_top.sv =====
// Top level of the keyframe pose interpolator.
// Depends on kpi_pkg, kpi_ctrl and kpi_dp.
`timescale 1ns / 1ps

// Usage:
//  - Input channel in_valid_i/in_ready_o/in_data_i carries one beat per item:
//    op 0 appends a control point, op 1 queries a pose at a time fraction.
//  - Output channel out_valid_o/out_ready_i/out_data_o returns exactly one
//    beat per item: status, pose, angles in radians and the point count.
//  - Configuration: cfg_we_i writes cfg_data_i into register cfg_addr_i
//    (0 rotation mode, 1 search tolerance); write while idle.
//  - Items are handled one at a time by a sequencer over a shared datapath.
//    A load checks for room and order and then writes the point; a query
//    runs a serial search over the points, a bit-serial divider and then the
//    six interpolations on one multiplier.
//  - A finished result waits in an output register; the next item is taken
//    meanwhile and only its own result waits for the receiver.
//  - Reset empties the point table (count zero) and sets three-axis mode
//    with a tolerance of 1; table contents are undefined until written.

module keyframe_pose_interpolator_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_addr_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  kpi_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output kpi_pkg::out_item_t out_data_o
);
  import kpi_pkg::*;

  kpi_cmd_t   cmd;
  kpi_flags_t flags;

  // Sequencer
  kpi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .flags_i    (flags),
    .cmd_o      (cmd)
  );

  // Datapath
  kpi_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .flags_o     (flags)
  );

endmodule

// ===== test/keyframe_pose_interpolator_top_tb.sv =====
// Self-checking testbench for keyframe_pose_interpolator_top: directed and random
// load and query beats are scored against an in-bench pose predictor.
// Depends on kpi_pkg and the RTL of the interpolator.
`timescale 1ns / 1ps

module keyframe_pose_interpolator_top_tb;
  import kpi_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic      cfg_addr_i = CFG_THREE_AXIS;
  logic [15:0] cfg_data_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  keyframe_pose_interpolator_top dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of the point table and registers
  logic [31:0]        kf_time [MAX_POINTS];
  logic signed [31:0] kf_shift[MAX_POINTS][3];
  logic signed [31:0] kf_angle[MAX_POINTS][3];
  int                 kf_held = 0;
  logic               mdl_three_axis = 1'b1;
  logic [15:0]        mdl_epsilon = 16'd1;

  out_item_t pose_queue[$];
  int        mismatches = 0;
  int        burst_left = 0;
  int        hold_req = 0;
  int        hold_cnt = 0;
  int        rx_cycle = 0;

  function automatic longint blend_axis(longint lo, longint hi, longint fac);
    longint v;
    v = lo + ((hi - lo) * fac) / 64'sd65536;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v;
  endfunction

  // Advance the table by one beat and return the pose it should produce
  function automatic out_item_t predict_pose(in_item_t it);
    out_item_t r;
    longint unsigned tv, last_t, fe, lhs, lo_t, hi_t, den, mag, q, rm, f, ti;
    longint num, fac, ang[3], sh[3];
    int i, n, j, k;
    r = '0;
    n = kf_held;
    tv = it.time_value;
    if (it.op == OP_LOAD) begin
      if (n >= MAX_POINTS) r.status = ST_FULL;
      else if (n > 0 && it.time_value < kf_time[n-1]) r.status = ST_ORDER;
      else begin
        kf_time[n] = it.time_value;
        kf_shift[n] = '{it.shift_x, it.shift_y, it.shift_z};
        kf_angle[n] = '{it.angle_x, it.angle_y, it.angle_z};
        kf_held = n + 1;
      end
    end else if (n < 2) begin
      r.status = ST_TOO_FEW;
    end else begin
      last_t = kf_time[n-1];
      fe = tv + mdl_epsilon;
      i = n;
      if (fe < 64'd65536) begin
        lhs = fe * last_t;
        for (i = 0; i < n; i++) begin
          ti = kf_time[i];
          if (lhs < (ti << 16)) break;
        end
      end
      if (i == n || i == 0) begin
        r.status = ST_NO_INTERVAL;
      end else begin
        lo_t = kf_time[i-1];
        hi_t = kf_time[i];
        num = longint'(tv * last_t) - longint'(lo_t << 16);
        den = (hi_t - lo_t) << 16;
        mag = (num < 0) ? longint'(-num) : num;
        q = mag / den;
        rm = mag % den;
        if (q >= 64'd32768) begin
          f = 64'h8000_0000;
        end else begin
          f = q << 16;
          for (k = 15; k >= 0; k--) begin
            rm = rm << 1;
            if (rm >= den) begin
              rm = rm - den;
              f = f | (64'd1 << k);
            end
          end
          if (f > 64'h8000_0000) f = 64'h8000_0000;
        end
        fac = (num < 0) ? -longint'(f) : longint'(f);
        for (j = 0; j < 3; j++) begin
          sh[j] = blend_axis(kf_shift[i-1][j], kf_shift[i][j], fac);
          ang[j] = (blend_axis(kf_angle[i-1][j], kf_angle[i][j], fac) *
                    longint'(RAD_PER_DEG_Q32)) / 64'sd4294967296;
        end
        r.pose_x = sh[0][31:0];
        r.pose_y = sh[1][31:0];
        r.pose_z = sh[2][31:0];
        if (mdl_three_axis) begin
          r.turn_first  = ang[0][31:0];
          r.turn_second = ang[1][31:0];
          r.turn_third  = ang[2][31:0];
        end else begin
          r.turn_first  = ang[2][31:0];
          r.turn_second = ang[0][31:0];
        end
      end
    end
    r.points_held = kf_held[HELD_W-1:0];
    return r;
  endfunction

  // Offer one beat, hold it until taken, then log the expected pose
  task automatic send_item(in_item_t it);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    pose_queue = {pose_queue, predict_pose(it)};
  endtask

  // Bursts of back-to-back beats separated by random gaps
  task automatic send_paced(in_item_t it);
    send_item(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait for every expected pose to come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pose_queue.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_THREE_AXIS) mdl_three_axis = val[0];
    else mdl_epsilon = val;
    @(posedge clk_i);
  endtask

  function automatic in_item_t mk_load(logic [31:0] t);
    in_item_t it;
    it = '0;
    it.op = OP_LOAD;
    it.time_value = t;
    it.shift_x = $urandom; it.shift_y = $urandom; it.shift_z = $urandom;
    it.angle_x = $urandom; it.angle_y = $urandom; it.angle_z = $urandom;
    return it;
  endfunction

  function automatic in_item_t mk_query(logic [31:0] f);
    in_item_t it;
    it = mk_load(f);
    it.op = OP_QUERY;
    return it;
  endfunction

  // Mostly fractions in range, some extremes and raw 32-bit noise
  function automatic in_item_t rand_query();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return mk_query($urandom_range(0, 65536));
    if (pick == 7) return mk_query(($urandom_range(0, 1) != 0) ? 32'd0 : 32'd65536);
    return mk_query($urandom);
  endfunction

  // Loads in order while there is room, with some out-of-order ones
  function automatic in_item_t rand_load();
    logic [31:0] last_t;
    last_t = (kf_held > 0) ? kf_time[kf_held-1] : 32'd0;
    if (kf_held >= MAX_POINTS || $urandom_range(0, 4) == 0) begin
      if (last_t > 0) return mk_load($urandom_range(0, last_t - 1));
      return mk_load($urandom);
    end
    if ($urandom_range(0, 5) == 0) return mk_load(last_t);
    return mk_load(last_t + $urandom_range(1, 200000));
  endfunction

  task automatic test_directed();
    in_item_t it;
    send_paced(mk_query(32'd32768));           // too few, empty table
    it = mk_load(32'd0);
    it.shift_x = 32'sh7FFF_FFFF; it.shift_y = 32'sh8000_0000; it.shift_z = 0;
    it.angle_x = 32'sh7FFF_FFFF; it.angle_y = 32'sh8000_0000; it.angle_z = -1;
    send_paced(it);
    send_paced(mk_query(32'd0));               // too few, one point
    it.shift_x = 32'sh8000_0000; it.shift_y = 32'sh7FFF_FFFF;
    it.angle_x = 32'sh8000_0000; it.angle_y = 32'sh7FFF_FFFF;
    send_paced(it);                            // equal time accepted
    send_paced(mk_query(32'd0));               // last time zero
    send_paced(mk_load(32'h0001_0000));
    send_paced(mk_load(32'h0000_8000));        // out of order
    send_paced(mk_query(32'd0));
    send_paced(mk_query(32'd65536));
    send_paced(mk_query(32'd32768));
    send_paced(mk_query(32'hFFFF_FFFF));
    it = mk_load(32'h0003_0000);
    it.angle_x = 32'sh8000_0000; it.angle_z = 32'sh7FFF_FFFF;
    send_paced(it);
    send_paced(mk_query(32'd40000));
    send_paced(mk_query(32'd21845));
    drain();
    write_reg(CFG_THREE_AXIS, 16'd0);          // two-angle order
    send_paced(mk_query(32'd40000));
    send_paced(mk_query(32'd10000));
    drain();
    write_reg(CFG_EPSILON, 16'hFFFF);          // extrapolation before point
    send_paced(mk_query(32'd0));
    send_paced(mk_query(32'd1));
    drain();
  endtask

  task automatic test_table_fill();
    write_reg(CFG_EPSILON, 16'd0);
    while (kf_held < MAX_POINTS - 1) begin
      if ($urandom_range(0, 1) != 0) send_paced(rand_load());
      else send_paced(rand_query());
    end
    send_paced(mk_load(32'hFFFF_FFFF));        // largest last time
    send_paced(mk_load(32'hFFFF_FFFF));        // table full
    send_paced(mk_load(32'd0));
    drain();
  endtask

  task automatic test_random_mix(logic axis, logic [15:0] eps, int count);
    write_reg(CFG_THREE_AXIS, {15'd0, axis});
    write_reg(CFG_EPSILON, eps);
    repeat (count) begin
      if ($urandom_range(0, 7) == 0) send_paced(rand_load());
      else send_paced(rand_query());
    end
    drain();
  endtask

  // Hold off the receiver while beats keep coming so the input stalls
  task automatic test_backpressure();
    hold_req = 400;
    repeat (30) send_item(rand_query());
    drain();
  endtask

  task automatic test_pause_and_resume();
    repeat (20) send_paced(rand_query());
    drain();
    repeat (20) send_paced(rand_query());
    drain();
  endtask

  // Receiver stalls: quiet stretches, random stalls, and long holds on request
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else if (rx_cycle[6]) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 2) != 0);
    end
  end

  // Score each returned beat against the oldest expected pose
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pose_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_data_o);
      end else begin
        want = pose_queue.pop_front();
        if (out_data_o.status !== want.status || out_data_o.pose_x !== want.pose_x ||
            out_data_o.pose_y !== want.pose_y || out_data_o.pose_z !== want.pose_z ||
            out_data_o.turn_first !== want.turn_first ||
            out_data_o.turn_second !== want.turn_second ||
            out_data_o.turn_third !== want.turn_third ||
            out_data_o.points_held !== want.points_held) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t", $time);
            $display("  expected %p", want);
            $display("  actual   %p", out_data_o);
          end
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_fill();
    test_random_mix(1'b0, 16'd0, 130);
    test_random_mix(1'b1, 16'hFFFF, 110);
    test_random_mix(1'b0, 16'($urandom_range(0, 2000)), 110);
    test_backpressure();
    test_pause_and_resume();
    test_random_mix(1'b1, 16'd1, 100);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && pose_queue.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
design/kpi_pkg.sv
design/kpi_ctrl.sv
design/kpi_dp.sv
design/keyframe_pose_interpolator_top.sv
test/keyframe_pose_interpolator_top_tb.sv
